FILE: hdl/rpv_pkg.sv
// ----------------------------------------------------------------------------
// rpv_pkg
// Shared types, character codes and helper functions for the relative path
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpv_pkg;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic       path_status;
        logic [7:0] component_total;
    } t_out_beat;

    typedef logic [3:0][7:0] t_stem;

    // Restriction on the second byte of a multi-byte UTF-8 sequence
    typedef enum logic [2:0] {
        SB_NONE  = 3'd0,
        SB_GE_A0 = 3'd1,
        SB_LT_A0 = 3'd2,
        SB_GE_90 = 3'd3,
        SB_LE_8F = 3'd4
    } t_sb_rule;

    localparam logic [1:0] CFG_MAX_PATH  = 2'd0;
    localparam logic [1:0] CFG_MAX_COMP  = 2'd1;
    localparam logic [1:0] CFG_MAX_COUNT = 2'd2;

    localparam logic [11:0] RST_MAX_PATH  = 12'd1024;
    localparam logic [7:0]  RST_MAX_COMP  = 8'd255;
    localparam logic [7:0]  RST_MAX_COUNT = 8'd64;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    localparam logic [7:0] U8_CONT_MASK = 8'hC0;
    localparam logic [7:0] U8_CONT_TAG  = 8'h80;
    localparam logic [7:0] U8_ASCII_MAX = 8'h7F;
    localparam logic [7:0] U8_L2_LO     = 8'hC2;
    localparam logic [7:0] U8_L2_HI     = 8'hDF;
    localparam logic [7:0] U8_L3_LO     = 8'hE0;
    localparam logic [7:0] U8_L3_SUR    = 8'hED;
    localparam logic [7:0] U8_L3_HI     = 8'hEF;
    localparam logic [7:0] U8_L4_LO     = 8'hF0;
    localparam logic [7:0] U8_L4_HI     = 8'hF4;
    localparam logic [7:0] U8_A0        = 8'hA0;
    localparam logic [7:0] U8_90        = 8'h90;
    localparam logic [7:0] U8_8F        = 8'h8F;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        lower_ascii = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic bad_char(input logic [7:0] b);
        bad_char = (b < CH_SPACE) || (b == CH_DEL) || (b == CH_COLON) ||
                   (b == CH_LT) || (b == CH_GT) || (b == CH_QUOTE) ||
                   (b == CH_PIPE) || (b == CH_QMARK) || (b == CH_STAR);
    endfunction

    function automatic logic is_device_stem(input t_stem s, input logic [2:0] len);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       three;
        logic       four;
        c0 = lower_ascii(s[0]);
        c1 = lower_ascii(s[1]);
        c2 = lower_ascii(s[2]);
        three = (c0 == "c" && c1 == "o" && c2 == "n") ||
                (c0 == "p" && c1 == "r" && c2 == "n") ||
                (c0 == "a" && c1 == "u" && c2 == "x") ||
                (c0 == "n" && c1 == "u" && c2 == "l");
        four  = ((c0 == "c" && c1 == "o" && c2 == "m") ||
                 (c0 == "l" && c1 == "p" && c2 == "t")) &&
                s[3] >= "1" && s[3] <= "9";
        is_device_stem = (len == 3'd3 && three) || (len == 3'd4 && four);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/relative_path_validator.sv
// ----------------------------------------------------------------------------
// relative_path_validator
// Checks a relative path streamed one byte per beat and reports accept or
// reject with the component count after the final byte.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall / i_in_beat carry one path byte and
// a final-byte flag per beat. Output channel: o_out_valid / i_out_stall /
// o_out_beat carry one verdict per path (status, component total).
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 path limit, 1 component limit, 2 component count limit); write only
// while no path is in flight.
// Throughput: one byte per cycle. The path state registers update from the
// input register as each byte is taken, so nothing limits the rate but
// the receiver. A final byte is checked out of the input register and its
// verdict lands in the result register, which drives o_out_valid.
// Reset: clears all path state and both registers, and loads the limits
// with 1024, 255 and 64. No clearing pass is needed.
// Stall: a pending verdict holds while i_out_stall is high; non-final bytes
// keep flowing, and a final byte waits in the input register, which then
// raises o_in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module relative_path_validator #(
    parameter int PATH_LENGTH_BITS = 12
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  rpv_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output rpv_pkg::t_out_beat o_out_beat,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_index,
    input  wire [11:0]         i_cfg_data
);
    import rpv_pkg::*;

    logic [11:0] r_max_path;
    logic [7:0]  r_max_comp;
    logic [7:0]  r_max_count;

    logic        w_in_valid;
    t_in_beat    w_in_beat;
    logic        w_out_free;
    logic        w_fire;
    t_out_beat   w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_path  <= RST_MAX_PATH;
            r_max_comp  <= RST_MAX_COMP;
            r_max_count <= RST_MAX_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_PATH:  r_max_path  <= i_cfg_data;
                CFG_MAX_COMP:  r_max_comp  <= i_cfg_data[7:0];
                CFG_MAX_COUNT: r_max_count <= i_cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // A final byte needs a free result slot; other bytes always advance
    assign w_fire = w_in_valid && (!w_in_beat.final_byte || w_out_free);

    rpv_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_beat  (i_in_beat),
        .o_stall (o_in_stall),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_beat  (w_in_beat)
    );

    rpv_path_check #(
        .PATH_LENGTH_BITS (PATH_LENGTH_BITS)
    ) u_path_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_beat      (w_in_beat),
        .i_max_path  (r_max_path),
        .i_max_comp  (r_max_comp),
        .i_max_count (r_max_count),
        .o_result    (w_result)
    );

    rpv_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_in_beat.final_byte),
        .i_beat  (w_result),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_beat)
    );

    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_in_beat.final_byte |=> o_out_valid)
        else $error("final byte processed but no verdict registered");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !(w_fire && w_in_beat.final_byte))
        else $error("pending verdict overwritten while stalled");

    a_status_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.path_status == (o_out_beat.component_total == 8'd0)))
        else $error("verdict status and component total disagree");

endmodule

`default_nettype wire

FILE: hdl/rpv_in_reg.sv
// ----------------------------------------------------------------------------
// rpv_in_reg
// Input register: holds one path byte beat until the checker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpv_in_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  rpv_pkg::t_in_beat  i_beat,
    output logic               o_stall,
    input  wire                i_take,
    output logic               o_valid,
    output rpv_pkg::t_in_beat  o_beat
);
    import rpv_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;
    logic     w_load;

    assign w_load  = !r_valid || i_take;
    assign o_stall = !w_load;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rpv_path_check.sv
// ----------------------------------------------------------------------------
// rpv_path_check
// Running path state and per-byte checks; forms the verdict on a final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rpv_path_check #(
    parameter int PATH_LENGTH_BITS = 12
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_fire,
    input  rpv_pkg::t_in_beat  i_beat,
    input  wire [11:0]         i_max_path,
    input  wire [7:0]          i_max_comp,
    input  wire [7:0]          i_max_count,
    output rpv_pkg::t_out_beat o_result
);
    import rpv_pkg::*;

    localparam int P     = PATH_LENGTH_BITS;
    localparam int CMP_W = (P + 1 > 12) ? P + 1 : 12;

    logic [P-1:0] r_path_len, n_path_len;
    logic [7:0]   r_comp_len, n_comp_len;
    logic [7:0]   r_count,    n_count;
    logic         r_rej,      n_rej;
    logic [1:0]   r_pend,     n_pend;
    t_sb_rule     r_rule,     n_rule;
    t_stem        r_stem,     n_stem;
    logic [2:0]   r_stem_len, n_stem_len;
    logic         r_dot,      n_dot;
    logic [7:0]   r_prior,    n_prior;
    logic         r_start,    n_start;

    logic [P:0]   w_path_n;
    logic [8:0]   w_comp_n;
    logic [7:0]   w_b;
    logic         w_sep;
    logic         w_ok;
    logic         w_limits_ok;
    logic         w_bad;

    always_comb begin
        w_b        = i_beat.path_byte;
        w_sep      = (w_b == CH_SLASH) || (w_b == CH_BSLASH);
        n_rej      = r_rej;
        n_comp_len = r_comp_len;
        n_pend     = r_pend;
        n_rule     = r_rule;
        n_stem     = r_stem;
        n_stem_len = r_stem_len;
        n_dot      = r_dot;
        n_prior    = r_prior;
        n_count    = r_count;
        n_start    = 1'b0;
        w_ok       = 1'b1;
        w_comp_n   = {1'b0, r_comp_len} + 9'd1;

        w_path_n = {1'b0, r_path_len} + {{P{1'b0}}, 1'b1};
        if (CMP_W'(w_path_n) > CMP_W'(i_max_path)) begin
            n_rej = 1'b1;
        end
        n_path_len = w_path_n[P] ? {P{1'b1}} : w_path_n[P-1:0];

        if (!w_sep) begin
            if (w_comp_n > {1'b0, i_max_comp}) begin
                n_rej = 1'b1;
            end
            n_comp_len = w_comp_n[8] ? 8'hFF : w_comp_n[7:0];
            if (bad_char(w_b)) begin
                n_rej = 1'b1;
            end
            // UTF-8: continuation byte, or start of a new sequence
            if (r_pend != 2'd0) begin
                w_ok = (w_b & U8_CONT_MASK) == U8_CONT_TAG;
                case (r_rule)
                    SB_NONE:  ;
                    SB_GE_A0: if (w_b < U8_A0) w_ok = 1'b0;
                    SB_LT_A0: if (w_b >= U8_A0) w_ok = 1'b0;
                    SB_GE_90: if (w_b < U8_90) w_ok = 1'b0;
                    SB_LE_8F: if (w_b > U8_8F) w_ok = 1'b0;
                    default:  ;
                endcase
                if (!w_ok) begin
                    n_rej = 1'b1;
                end
                n_rule = SB_NONE;
                n_pend = r_pend - 2'd1;
            end else if (w_b <= U8_ASCII_MAX) begin
                n_pend = 2'd0;
            end else if (w_b >= U8_L2_LO && w_b <= U8_L2_HI) begin
                n_pend = 2'd1;
            end else if (w_b >= U8_L3_LO && w_b <= U8_L3_HI) begin
                n_pend = 2'd2;
                n_rule = (w_b == U8_L3_LO) ? SB_GE_A0 :
                         (w_b == U8_L3_SUR) ? SB_LT_A0 : SB_NONE;
            end else if (w_b >= U8_L4_LO && w_b <= U8_L4_HI) begin
                n_pend = 2'd3;
                n_rule = (w_b == U8_L4_LO) ? SB_GE_90 :
                         (w_b == U8_L4_HI) ? SB_LE_8F : SB_NONE;
            end else begin
                n_rej = 1'b1;
            end
            if (w_b == CH_DOT) begin
                n_dot = 1'b1;
            end
            if (!n_dot) begin
                if (r_stem_len < 3'd4) begin
                    n_stem[r_stem_len[1:0]] = w_b;
                end
                if (r_stem_len < 3'd5) begin
                    n_stem_len = r_stem_len + 3'd1;
                end
            end
            n_prior = w_b;
        end

        if (w_sep && (r_start || i_beat.final_byte)) begin
            n_rej = 1'b1;
        end

        // Close the component on a separator or at the end of the path
        if (w_sep || i_beat.final_byte) begin
            if (n_comp_len == 8'd0) begin
                n_rej = 1'b1;
            end
            if (r_count >= i_max_count) begin
                n_rej = 1'b1;
            end else if (r_count != 8'hFF) begin
                n_count = r_count + 8'd1;
            end
            if (n_pend != 2'd0) begin
                n_rej = 1'b1;
            end
            if (n_prior == CH_DOT || n_prior == CH_SPACE) begin
                n_rej = 1'b1;
            end
            if (is_device_stem(n_stem, n_stem_len)) begin
                n_rej = 1'b1;
            end
            n_comp_len = 8'd0;
            n_pend     = 2'd0;
            n_rule     = SB_NONE;
            n_stem     = '0;
            n_stem_len = 3'd0;
            n_dot      = 1'b0;
            n_prior    = 8'd0;
        end

        w_limits_ok = (i_max_path != 12'd0) && (i_max_comp != 8'd0) &&
                      (i_max_count != 8'd0) && ({4'd0, i_max_comp} <= i_max_path);
        w_bad = n_rej || !w_limits_ok || (n_count == 8'd0);
        o_result.path_status     = w_bad;
        o_result.component_total = w_bad ? 8'd0 : n_count;

        // Drop all path state after the last byte
        if (i_beat.final_byte) begin
            n_path_len = '0;
            n_count    = 8'd0;
            n_rej      = 1'b0;
            n_start    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= '0;
            r_comp_len <= 8'd0;
            r_count    <= 8'd0;
            r_rej      <= 1'b0;
            r_pend     <= 2'd0;
            r_rule     <= SB_NONE;
            r_stem     <= '0;
            r_stem_len <= 3'd0;
            r_dot      <= 1'b0;
            r_prior    <= 8'd0;
            r_start    <= 1'b1;
        end else if (i_fire) begin
            r_path_len <= n_path_len;
            r_comp_len <= n_comp_len;
            r_count    <= n_count;
            r_rej      <= n_rej;
            r_pend     <= n_pend;
            r_rule     <= n_rule;
            r_stem     <= n_stem;
            r_stem_len <= n_stem_len;
            r_dot      <= n_dot;
            r_prior    <= n_prior;
            r_start    <= n_start;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rpv_out_reg.sv
// ----------------------------------------------------------------------------
// rpv_out_reg
// Result register: holds one verdict beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpv_out_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  rpv_pkg::t_out_beat i_beat,
    output logic               o_free,
    output logic               o_valid,
    input  wire                i_stall,
    output rpv_pkg::t_out_beat o_beat
);
    import rpv_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb_relative_path_validator.sv
// ----------------------------------------------------------------------------
// tb_relative_path_validator
// Streams directed and random relative paths through the validator under a
// sweep of limit settings and idle patterns. A local model scores every byte,
// queues the verdict due on each final byte and checks the output against it.
// ----------------------------------------------------------------------------

module tb_relative_path_validator;

    import rpv_pkg::*;

    localparam int PATH_BITS      = 12;
    localparam int PATH_SAT       = (1 << PATH_BITS) - 1;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ROUND_BYTES    = 18;
    localparam int NUM_SETS       = 9;

    // unmapped register index, writes to it are ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // path, component and count limits, extremes and invalid mixes included
    localparam int LIMIT_SETS [NUM_SETS][3] = '{
        '{1024, 255, 64},
        '{4095, 255, 255},
        '{12, 4, 3},
        '{1, 1, 1},
        '{4, 4, 2},
        '{0, 5, 5},
        '{20, 0, 5},
        '{20, 5, 0},
        '{6, 8, 4}
    };

    localparam logic [23:0] DEVICE_NAMES [6] = '{"con", "prn", "aux", "nul", "com", "lpt"};
    localparam logic [7:0]  FORBIDDEN [9] = '{CH_COLON, CH_LT, CH_GT, CH_QUOTE, CH_PIPE,
                                              CH_QMARK, CH_STAR, CH_DEL, 8'h1F};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_beat;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_beat   o_out_beat;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    // model of the limits and of the running path state
    logic [11:0]          lim_path;
    logic [7:0]           lim_comp;
    logic [7:0]           lim_count;
    logic [PATH_BITS-1:0] path_len;
    logic [7:0]           comp_len;
    logic [7:0]           comp_cnt;
    logic                 rejected;
    logic [1:0]           u8_due;
    t_sb_rule             u8_rule;
    t_stem                stem;
    logic [2:0]           stem_len;
    logic                 dot_seen;
    logic [7:0]           last_byte;
    logic                 at_start;

    t_out_beat  verdict_q [$];
    logic [7:0] path_buf [$];

    int src_idle_pct   = 10;
    int sink_stall_pct = 86;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    relative_path_validator #(
        .PATH_LENGTH_BITS(PATH_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Path model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic logic reserved_stem();
        logic [23:0] head;
        head = {fold_case(stem[0]), fold_case(stem[1]), fold_case(stem[2])};
        if (stem_len == 3'd3) begin
            return head == "con" || head == "prn" || head == "aux" || head == "nul";
        end
        if (stem_len == 3'd4) begin
            return (head == "com" || head == "lpt") && stem[3] >= "1" && stem[3] <= "9";
        end
        return 1'b0;
    endfunction

    function automatic logic forbidden_char(input logic [7:0] b);
        case (b)
            CH_DEL, CH_COLON, CH_LT, CH_GT, CH_QUOTE, CH_PIPE, CH_QMARK, CH_STAR: begin
                return 1'b1;
            end
            default: begin
                return b < CH_SPACE;
            end
        endcase
    endfunction

    task automatic clear_component();
        comp_len  = '0;
        u8_due    = '0;
        u8_rule   = SB_NONE;
        stem      = '0;
        stem_len  = '0;
        dot_seen  = 1'b0;
        last_byte = '0;
    endtask

    task automatic clear_path();
        clear_component();
        path_len = '0;
        comp_cnt = '0;
        rejected = 1'b0;
        at_start = 1'b1;
    endtask

    task automatic close_component();
        if (comp_len == 8'd0) rejected = 1'b1;
        if (comp_cnt >= lim_count) begin
            rejected = 1'b1;
        end else if (comp_cnt != 8'd255) begin
            comp_cnt = comp_cnt + 8'd1;
        end
        if (u8_due != 2'd0) rejected = 1'b1;
        if (last_byte == CH_DOT || last_byte == CH_SPACE) rejected = 1'b1;
        if (reserved_stem()) rejected = 1'b1;
        clear_component();
    endtask

    task automatic track_utf8(input logic [7:0] b);
        logic ok;
        if (u8_due != 2'd0) begin
            ok = (b & U8_CONT_MASK) == U8_CONT_TAG;
            case (u8_rule)
                SB_GE_A0: if (b < U8_A0) ok = 1'b0;
                SB_LT_A0: if (b >= U8_A0) ok = 1'b0;
                SB_GE_90: if (b < U8_90) ok = 1'b0;
                SB_LE_8F: if (b > U8_8F) ok = 1'b0;
                default: ;
            endcase
            if (!ok) rejected = 1'b1;
            u8_rule = SB_NONE;
            u8_due  = u8_due - 2'd1;
        end else if (b > U8_ASCII_MAX) begin
            if (b >= U8_L2_LO && b <= U8_L2_HI) begin
                u8_due = 2'd1;
            end else if (b >= U8_L3_LO && b <= U8_L3_HI) begin
                u8_due = 2'd2;
                if (b == U8_L3_LO) u8_rule = SB_GE_A0;
                else if (b == U8_L3_SUR) u8_rule = SB_LT_A0;
                else u8_rule = SB_NONE;
            end else if (b >= U8_L4_LO && b <= U8_L4_HI) begin
                u8_due = 2'd3;
                if (b == U8_L4_LO) u8_rule = SB_GE_90;
                else if (b == U8_L4_HI) u8_rule = SB_LE_8F;
                else u8_rule = SB_NONE;
            end else begin
                rejected = 1'b1;
            end
        end
    endtask

    task automatic score_name_byte(input logic [7:0] b);
        int n;
        n = comp_len + 1;
        if (n > lim_comp) rejected = 1'b1;
        comp_len = (n > 255) ? 8'd255 : 8'(n);
        if (forbidden_char(b)) rejected = 1'b1;
        track_utf8(b);
        if (b == CH_DOT) dot_seen = 1'b1;
        if (!dot_seen) begin
            if (stem_len < 3'd4) stem[stem_len[1:0]] = b;
            if (stem_len < 3'd5) stem_len = stem_len + 3'd1;
        end
        last_byte = b;
    endtask

    // advance the model by one accepted beat; a final byte queues a verdict
    task automatic score_path_byte(input logic [7:0] b, input logic fin);
        int        n;
        logic      limits_ok;
        t_out_beat v;
        n = path_len + 1;
        if (n > lim_path) rejected = 1'b1;
        path_len = (n > PATH_SAT) ? PATH_BITS'(PATH_SAT) : PATH_BITS'(n);
        if (b == CH_SLASH || b == CH_BSLASH) begin
            if (at_start || fin) rejected = 1'b1;
            close_component();
        end else begin
            score_name_byte(b);
            if (fin) close_component();
        end
        at_start = 1'b0;
        if (fin) begin
            limits_ok = lim_path != 12'd0 && lim_comp != 8'd0 && lim_count != 8'd0 &&
                        {4'd0, lim_comp} <= lim_path;
            v.path_status     = rejected || !limits_ok || comp_cnt == 8'd0;
            v.component_total = v.path_status ? 8'd0 : comp_cnt;
            verdict_q.push_back(v);
            clear_path();
        end
    endtask

    // ------------------------------------------------------------------------
    // Verdict checker and receiver stall
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict with no path pending: path_status %0d, component_total %0d",
                           o_out_beat.path_status, o_out_beat.component_total);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out_beat.path_status !== want.path_status) begin
                        $error("path_status: expected %0d, got %0d",
                               want.path_status, o_out_beat.path_status);
                        fail_count++;
                    end
                    if (o_out_beat.component_total !== want.component_total) begin
                        $error("component_total: expected %0d, got %0d",
                               want.component_total, o_out_beat.component_total);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= '{path_byte: b, final_byte: fin};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        score_path_byte(b, fin);
    endtask

    task automatic send_path();
        int last;
        last = path_buf.size() - 1;
        foreach (path_buf[i]) send_beat(path_buf[i], i == last);
    endtask

    // hold the sender until every verdict is in, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limits(input int path, input int comp, input int count);
        logic [11:0] junk;
        junk = 12'($urandom);
        // upper data bits on the 8-bit registers must be dropped
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_PATH;
        i_cfg_data  <= 12'(path);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_COMP;
        i_cfg_data  <= {junk[11:8], 8'(comp)};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_COUNT;
        i_cfg_data  <= {junk[7:4], 8'(count)};
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= junk;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_path  = 12'(path);
        lim_comp  = 8'(comp);
        lim_count = 8'(count);
    endtask

    // ------------------------------------------------------------------------
    // Path generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(61);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    function automatic int name_size();
        int cap;
        cap = (lim_comp > 8'd10) ? 10 : int'(lim_comp);
        if ($urandom_range(9) == 0) return cap + $urandom_range(1);
        return $urandom_range(6, 1);
    endfunction

    task automatic push_name(input int len);
        repeat (len) path_buf.push_back(name_char());
    endtask

    task automatic push_utf8_good();
        logic [7:0] lead;
        case ($urandom_range(3))
            0: begin
                path_buf.push_back(8'($urandom_range(U8_L2_HI, U8_L2_LO)));
                path_buf.push_back(cont_byte());
            end
            1: begin
                lead = 8'($urandom_range(U8_L3_HI, U8_L3_LO));
                path_buf.push_back(lead);
                if (lead == U8_L3_LO) path_buf.push_back(8'($urandom_range(8'hBF, U8_A0)));
                else if (lead == U8_L3_SUR) path_buf.push_back(8'($urandom_range(8'h9F, 8'h80)));
                else path_buf.push_back(cont_byte());
                path_buf.push_back(cont_byte());
            end
            2: begin
                lead = 8'($urandom_range(U8_L4_HI, U8_L4_LO));
                path_buf.push_back(lead);
                if (lead == U8_L4_LO) path_buf.push_back(8'($urandom_range(8'hBF, U8_90)));
                else if (lead == U8_L4_HI) path_buf.push_back(8'($urandom_range(U8_8F, 8'h80)));
                else path_buf.push_back(cont_byte());
                path_buf.push_back(cont_byte());
                path_buf.push_back(cont_byte());
            end
            default: path_buf.push_back(name_char());
        endcase
    endtask

    task automatic push_utf8_bad();
        case ($urandom_range(7))
            0: begin
                // overlong two-byte lead
                path_buf.push_back(8'($urandom_range(8'hC1, 8'hC0)));
                path_buf.push_back(cont_byte());
            end
            1: path_buf.push_back(8'($urandom_range(8'hFF, 8'hF5)));
            2: begin
                path_buf.push_back(U8_L3_LO);
                path_buf.push_back(8'($urandom_range(8'h9F, 8'h80)));
                path_buf.push_back(cont_byte());
            end
            3: begin
                // surrogate range
                path_buf.push_back(U8_L3_SUR);
                path_buf.push_back(8'($urandom_range(8'hBF, U8_A0)));
                path_buf.push_back(cont_byte());
            end
            4: begin
                path_buf.push_back(U8_L4_LO);
                path_buf.push_back(8'($urandom_range(U8_8F, 8'h80)));
                path_buf.push_back(cont_byte());
                path_buf.push_back(cont_byte());
            end
            5: begin
                // above the last code point
                path_buf.push_back(U8_L4_HI);
                path_buf.push_back(8'($urandom_range(8'hBF, U8_90)));
                path_buf.push_back(cont_byte());
                path_buf.push_back(cont_byte());
            end
            6: path_buf.push_back(cont_byte());
            default: begin
                // lead byte and at most one continuation: truncated unless a two-byte lead
                path_buf.push_back(8'($urandom_range(8'hF3, U8_L2_LO)));
                if ($urandom_range(1)) path_buf.push_back(cont_byte());
            end
        endcase
    endtask

    task automatic push_device_stem();
        int          k;
        logic [23:0] name;
        logic [7:0]  c;
        k = $urandom_range(5);
        name = DEVICE_NAMES[k];
        for (int i = 2; i >= 0; i--) begin
            c = name[i*8 +: 8];
            if ($urandom_range(1)) c = c - 8'd32;
            path_buf.push_back(c);
        end
        if (k >= 4) path_buf.push_back(8'($urandom_range("9", "0")));
        case ($urandom_range(3))
            0: ;
            1: begin
                path_buf.push_back(CH_DOT);
                push_name($urandom_range(3, 1));
            end
            2: push_name(1);
            default: path_buf.push_back(CH_DOT);
        endcase
    endtask

    task automatic push_component();
        int kind;
        kind = $urandom_range(99);
        if (kind < 35) begin
            push_name(name_size());
        end else if (kind < 50) begin
            repeat ($urandom_range(3, 1)) push_utf8_good();
        end else if (kind < 60) begin
            push_device_stem();
        end else if (kind < 68) begin
            push_name($urandom_range(2));
            push_utf8_bad();
            push_name($urandom_range(1));
        end else if (kind < 76) begin
            push_name($urandom_range(2));
            if ($urandom_range(1)) path_buf.push_back(FORBIDDEN[$urandom_range(8)]);
            else path_buf.push_back(8'($urandom_range(31)));
            push_name($urandom_range(2));
        end else if (kind < 82) begin
            push_name($urandom_range(3, 1));
            path_buf.push_back($urandom_range(1) ? CH_DOT : CH_SPACE);
        end else if (kind < 86) begin
            // interior space and dot: legal, and the dot cuts the stem short
            push_name(1);
            path_buf.push_back(CH_SPACE);
            push_name($urandom_range(2, 1));
            path_buf.push_back(CH_DOT);
            push_name($urandom_range(2, 1));
        end else if (kind < 91) begin
            // empty component
        end else begin
            repeat ($urandom_range(4, 1)) path_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic build_path();
        int cap;
        int ncomp;
        path_buf.delete();
        cap = (lim_count > 8'd5) ? 5 : int'(lim_count);
        ncomp = ($urandom_range(9) == 0) ? cap + $urandom_range(1) : $urandom_range(4, 1);
        if (ncomp == 0) ncomp = 1;
        if ($urandom_range(19) == 0) path_buf.push_back($urandom_range(1) ? CH_SLASH : CH_BSLASH);
        for (int i = 0; i < ncomp; i++) begin
            if (i > 0) path_buf.push_back($urandom_range(1) ? CH_SLASH : CH_BSLASH);
            push_component();
        end
        if ($urandom_range(19) == 0) path_buf.push_back($urandom_range(1) ? CH_SLASH : CH_BSLASH);
        if (path_buf.size() == 0) path_buf.push_back(name_char());
    endtask

    task automatic send_random_paths(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            build_path();
            sent += path_buf.size();
            send_path();
            if ($urandom_range(49) == 0) wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_paths();
        path_buf = '{CH_SLASH, "a"};                    // leading separator
        send_path();
        path_buf = '{"a", CH_BSLASH};                   // trailing separator
        send_path();
        path_buf = '{"a", CH_SLASH, CH_SLASH, "b"};     // empty component
        send_path();
        path_buf = '{"N", "u", "L"};                    // device name, mixed case
        send_path();
        path_buf = '{"L", "P", "T", "1"};
        send_path();
        path_buf = '{"x", CH_DOT};                      // trailing dot
        send_path();
        path_buf = '{U8_L3_SUR, U8_A0, U8_CONT_TAG};    // encoded surrogate
        send_path();
        path_buf = '{8'h00};
        send_path();
        path_buf = '{8'hFF};
        send_path();
        path_buf = '{U8_L4_HI, U8_8F, 8'hBF, 8'hBF};    // highest code point, legal
        send_path();
    endtask

    task automatic test_limit_sweep();
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct   = (mode == 0) ? 10 : (mode == 1) ? 86 : 0;
            sink_stall_pct = (mode == 0) ? 86 : (mode == 1) ? 10 : 0;
            for (int k = 0; k < NUM_SETS; k++) begin
                wait_drained();
                set_limits(LIMIT_SETS[k][0], LIMIT_SETS[k][1], LIMIT_SETS[k][2]);
                send_random_paths(ROUND_BYTES);
            end
        end
    endtask

    task automatic test_long_paths();
        wait_drained();
        set_limits(4095, 255, 255);
        // one component at the full component limit
        path_buf.delete();
        repeat (255) path_buf.push_back(name_char());
        send_path();
        // the most components the count allows
        path_buf.delete();
        for (int i = 0; i < 255; i++) begin
            if (i > 0) path_buf.push_back($urandom_range(1) ? CH_SLASH : CH_BSLASH);
            path_buf.push_back(name_char());
        end
        send_path();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_beat   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_MAX_PATH;
        i_cfg_data  <= '0;
        lim_path  = RST_MAX_PATH;
        lim_comp  = RST_MAX_COMP;
        lim_count = RST_MAX_COUNT;
        clear_path();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_paths();
        test_limit_sweep();
        test_long_paths();
        wait_drained();

        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/rpv_pkg.sv
hdl/rpv_in_reg.sv
hdl/rpv_path_check.sv
hdl/rpv_out_reg.sv
hdl/relative_path_validator.sv
sim/tb_relative_path_validator.sv
